// ===== rtl/cesd_pkg.sv =====
`default_nettype none
package cesd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  localparam logic [7:0] MAX_LEN_RESET = 8'd31;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_N   = 8'h6e;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;

  // Control codes of the letter escapes.
  localparam logic [7:0] CODE_BS = 8'd8;
  localparam logic [7:0] CODE_HT = 8'd9;
  localparam logic [7:0] CODE_LF = 8'd10;
  localparam logic [7:0] CODE_VT = 8'd11;
  localparam logic [7:0] CODE_FF = 8'd12;
  localparam logic [7:0] CODE_CR = 8'd13;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_OCT,
    MODE_HEX
  } mode_t;

  // One classified character, as the front hands it to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       nul;
    logic       term;
    logic       bslash;
    logic       is_x;
    logic       oct_ok;
    logic [2:0] oct_val;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       esc_ok;
    logic [7:0] esc_val;
  } cls_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] length;
    logic [9:0] chars_used;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/cesd_front.sv =====
`default_nettype none
module cesd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    ch,
  output logic               head_valid,
  output cesd_pkg::cls_t     head,
  input  wire logic          head_pop
);
  import cesd_pkg::*;

  cls_t       cls;
  cls_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       wr_ok;
  logic       rd_ok;
  logic [7:0] hex_tmp;

  always_comb begin
    hex_tmp     = 8'd0;
    cls         = '0;
    cls.ch      = ch;
    cls.nul     = (ch == CH_NUL);
    cls.term    = (ch == CH_NUL) || (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    cls.bslash  = (ch == CH_BSLASH);
    cls.is_x    = (ch == CH_X);
    cls.oct_ok  = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
    cls.oct_val = ch[2:0];
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cls.hex_ok = 1'b1;
      hex_tmp    = ch - CH_ZERO;
    end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
      cls.hex_ok = 1'b1;
      hex_tmp    = ch - CH_LC_A + 8'd10;
    end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
      cls.hex_ok = 1'b1;
      hex_tmp    = ch - CH_UC_A + 8'd10;
    end
    cls.hex_val = hex_tmp[3:0];
    cls.esc_ok  = 1'b1;
    unique case (ch)
      CH_LC_N: cls.esc_val = CODE_LF;
      CH_LC_R: cls.esc_val = CODE_CR;
      CH_LC_B: cls.esc_val = CODE_BS;
      CH_LC_T: cls.esc_val = CODE_HT;
      CH_LC_F: cls.esc_val = CODE_FF;
      CH_LC_V: cls.esc_val = CODE_VT;
      default: begin
        cls.esc_ok  = 1'b0;
        cls.esc_val = 8'd0;
      end
    endcase
  end

  assign full       = (count == 3'd4);
  assign head_valid = (count != 3'd0);
  assign head       = q[rp];
  assign wr_ok      = push && !full;
  assign rd_ok      = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      count <= 3'd0;
    end else begin
      if (wr_ok) begin
        wp <= wp + 2'd1;
      end
      if (rd_ok) begin
        rp <= rp + 2'd1;
      end
      count <= count + {2'd0, wr_ok} - {2'd0, rd_ok};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cesd_back.sv =====
`default_nettype none
module cesd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    max_len,
  input  wire logic          head_valid,
  input  wire cesd_pkg::cls_t head,
  output logic               head_pop,
  output logic               empty,
  input  wire logic          pop,
  output cesd_pkg::res_t     res_head
);
  import cesd_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [11:0] acc;
  logic [11:0] acc_next;
  logic [1:0]  dcnt;
  logic [1:0]  dcnt_next;
  logic [7:0]  bcnt;
  logic [7:0]  bcnt_next;
  logic [9:0]  ucnt;
  logic [9:0]  ucnt_next;

  res_t        res0;
  res_t        res1;
  res_t        pres;
  logic [1:0]  n_res;
  logic        take;
  logic        run_plain;
  logic        pres_valid;
  logic [7:0]  bcnt_p;
  logic        dig_ok;
  logic [11:0] acc_dig;

  res_t        oq [4];
  logic [1:0]  owp;
  logic [1:0]  orp;
  logic [2:0]  ocount;
  logic        out_ok;

  function automatic res_t mk_res(logic [1:0] k, logic [7:0] b, logic [7:0] len,
                                  logic [9:0] used);
    res_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.length     = len;
    r.chars_used = used;
    r.last       = 1'b0;
    return r;
  endfunction

  // A character is taken only when the result queue has room for two results.
  assign take     = head_valid && (ocount <= 3'd2);
  assign head_pop = take;

  always_comb begin
    mode_next  = mode;
    acc_next   = acc;
    dcnt_next  = dcnt;
    bcnt_next  = bcnt;
    ucnt_next  = ucnt;
    res0       = '0;
    res1       = '0;
    pres       = '0;
    pres_valid = 1'b0;
    n_res      = 2'd0;
    run_plain  = 1'b0;
    bcnt_p     = bcnt;
    dig_ok     = 1'b0;
    acc_dig    = 12'd0;
    if (take) begin
      unique case (mode)
        MODE_PLAIN: run_plain = 1'b1;
        MODE_ESC: begin
          ucnt_next = ucnt + 10'd1;
          mode_next = MODE_PLAIN;
          if (head.nul) begin
            res0      = mk_res(KIND_END, 8'd0, bcnt, ucnt + 10'd1);
            n_res     = 2'd1;
            acc_next  = 12'd0;
            dcnt_next = 2'd0;
            bcnt_next = 8'd0;
            ucnt_next = 10'd0;
          end else if (head.esc_ok) begin
            bcnt_next = bcnt + 8'd1;
            res0      = mk_res(KIND_BYTE, head.esc_val, bcnt + 8'd1, ucnt + 10'd1);
            n_res     = 2'd1;
          end else if (head.is_x) begin
            mode_next = MODE_HEX;
            acc_next  = 12'd0;
            dcnt_next = 2'd0;
          end else if (head.oct_ok) begin
            mode_next = MODE_OCT;
            acc_next  = {9'd0, head.oct_val};
            dcnt_next = 2'd1;
          end else begin
            bcnt_next = bcnt + 8'd1;
            res0      = mk_res(KIND_BYTE, head.ch, bcnt + 8'd1, ucnt + 10'd1);
            n_res     = 2'd1;
          end
        end
        MODE_OCT, MODE_HEX: begin
          dig_ok  = (mode == MODE_OCT) ? head.oct_ok : head.hex_ok;
          acc_dig = (mode == MODE_OCT) ? {acc[8:0], head.oct_val} : {acc[7:0], head.hex_val};
          if (dig_ok) begin
            ucnt_next = ucnt + 10'd1;
            if (dcnt == 2'd2) begin
              bcnt_next = bcnt + 8'd1;
              res0      = mk_res(KIND_BYTE, acc_dig[7:0], bcnt + 8'd1, ucnt + 10'd1);
              n_res     = 2'd1;
              mode_next = MODE_PLAIN;
              acc_next  = 12'd0;
              dcnt_next = 2'd0;
            end else begin
              acc_next  = acc_dig;
              dcnt_next = dcnt + 2'd1;
            end
          end else begin
            // The escape's byte goes out first, then the character starts over.
            res0      = mk_res(KIND_BYTE, (dcnt != 2'd0) ? acc[7:0] : CH_X,
                               bcnt + 8'd1, ucnt);
            n_res     = 2'd1;
            bcnt_p    = bcnt + 8'd1;
            bcnt_next = bcnt + 8'd1;
            mode_next = MODE_PLAIN;
            acc_next  = 12'd0;
            dcnt_next = 2'd0;
            run_plain = 1'b1;
          end
        end
        default: ;
      endcase

      if (run_plain) begin
        if (head.term) begin
          pres       = mk_res(KIND_END, 8'd0, bcnt_p, ucnt + 10'd1);
          pres_valid = 1'b1;
          mode_next  = MODE_PLAIN;
          acc_next   = 12'd0;
          dcnt_next  = 2'd0;
          bcnt_next  = 8'd0;
          ucnt_next  = 10'd0;
        end else if (bcnt_p >= max_len) begin
          // The character at the limit is dropped and not counted.
          pres       = mk_res(KIND_OVF, 8'd0, bcnt_p, ucnt);
          pres_valid = 1'b1;
          mode_next  = MODE_PLAIN;
          acc_next   = 12'd0;
          dcnt_next  = 2'd0;
          bcnt_next  = 8'd0;
          ucnt_next  = 10'd0;
        end else begin
          ucnt_next = ucnt + 10'd1;
          if (head.bslash) begin
            mode_next = MODE_ESC;
          end else begin
            bcnt_next  = bcnt_p + 8'd1;
            pres       = mk_res(KIND_BYTE, head.ch, bcnt_p + 8'd1, ucnt + 10'd1);
            pres_valid = 1'b1;
          end
        end
        if (pres_valid) begin
          if (n_res == 2'd0) begin
            res0  = pres;
            n_res = 2'd1;
          end else begin
            res1  = pres;
            n_res = 2'd2;
          end
        end
      end

      if (n_res == 2'd1) begin
        res0.last = 1'b1;
      end else if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      acc  <= 12'd0;
      dcnt <= 2'd0;
      bcnt <= 8'd0;
      ucnt <= 10'd0;
    end else begin
      mode <= mode_next;
      acc  <= acc_next;
      dcnt <= dcnt_next;
      bcnt <= bcnt_next;
      ucnt <= ucnt_next;
    end
  end

  assign empty    = (ocount == 3'd0);
  assign res_head = oq[orp];
  assign out_ok   = pop && !empty;

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      oq[owp] <= res0;
    end
    if (n_res == 2'd2) begin
      oq[owp + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= 2'd0;
      orp    <= 2'd0;
      ocount <= 3'd0;
    end else begin
      owp <= owp + n_res;
      if (out_ok) begin
        orp <= orp + 2'd1;
      end
      ocount <= ocount + {1'b0, n_res} - {2'd0, out_ok};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/c_escape_string_decoder_unit.sv =====
`default_nettype none
// Decoder for C-style escaped tokens, one raw character per transaction.
// Input side is a queue: a character on ch is taken when push is high and
// full is low. Result side is a queue too: the oldest result sits on kind,
// out_byte, length, chars_used and last while empty is low, and pop takes it.
// Each character gives zero, one or two results; last marks the final one.
// The front classifies characters into a four-entry queue; the back runs
// the escape state machine, one character per cycle while the result queue
// has room, into a four-entry result queue. Each character is registered in
// the input queue and its results in the result queue once it is taken.
// The back takes a character only when the result queue has room for two.
// With a receiver that pops every cycle the block moves one result per cycle,
// so it sustains one character per cycle while characters give at most one
// result each; characters that give two results can make the back wait.
// A stalled receiver fills the result queue and then the input queue, after
// which full rises. max_len is written through cfg_wen and cfg_wdata. The
// user must do so only while no character is in flight; the block does not
// enforce it. A write in the middle of a token applies from the next limit
// check. Reset clears both queues, the token state and sets max_len to 31.
module c_escape_string_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] ch,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic [7:0]      length,
  output logic [9:0]      chars_used,
  output logic            last,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata
);
  import cesd_pkg::*;

  logic [7:0] max_len;
  logic       head_valid;
  logic       head_pop;
  cls_t       head;
  res_t       res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_wen) begin
      max_len <= cfg_wdata;
    end
  end

  cesd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .ch         (ch),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  cesd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .max_len    (max_len),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .res_head   (res_head)
  );

  assign kind       = res_head.kind;
  assign out_byte   = res_head.out_byte;
  assign length     = res_head.length;
  assign chars_used = res_head.chars_used;
  assign last       = res_head.last;

endmodule
`default_nettype wire
